// ----- hw/rtl/key_short_long_press_classifier_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the key press classifier
// Shared concurrent-assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef KEY_SHORT_LONG_PRESS_CLASSIFIER_DEFINES_SVH
`define KEY_SHORT_LONG_PRESS_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while rst is high
`define KSLP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("key classifier check failed");

// Next-cycle implication, disabled while rst is high
`define KSLP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key classifier check failed");

`endif

// ----- hw/rtl/kslp_pkg.sv -----
// ---------------------------------------------------------------------------
// kslp_pkg
// Types and codes shared by the key press classifier modules.
// ---------------------------------------------------------------------------
package kslp_pkg;

   // Event codes carried in the result beat
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_SHORT = 2'd1;
   localparam logic [1:0] EV_LONG  = 2'd2;

   // Register indexes on the csr port
   localparam logic [1:0] REG_CONFIRM = 2'd0;
   localparam logic [1:0] REG_LONG    = 2'd1;
   localparam logic [1:0] REG_SETTLE  = 2'd2;

   // Register reset values
   localparam logic [15:0] CONFIRM_RESET = 16'd50;
   localparam logic [15:0] LONG_RESET    = 16'd5000;
   localparam logic [7:0]  SETTLE_RESET  = 8'd2;

   // Timing thresholds handed to the classifier core
   typedef struct packed {
      logic [15:0] confirm_ticks;
      logic [15:0] long_ticks;
      logic [7:0]  settle_ticks;
   } cfg_type;

endpackage

// ----- hw/rtl/kslp_core.sv -----
// ---------------------------------------------------------------------------
// kslp_core
// Debounce and short/long classification state machine, one sample per step.
// ---------------------------------------------------------------------------
module kslp_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic              key_pressed,
   input  kslp_pkg::cfg_type cfg,
   output logic [1:0]        event_res
);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_CONFIRM = 3'd1;
   localparam logic [2:0] PH_HELD    = 3'd2;
   localparam logic [2:0] PH_REPORT  = 3'd3;
   localparam logic [2:0] PH_WAIT    = 3'd4;

   logic [2:0]  phase_ff,   phase_in;
   logic [15:0] hold_ff,    hold_in;
   logic [7:0]  release_ff, release_in;
   logic        long_ff,    long_in;
   logic [15:0] hold_inc;
   logic [7:0]  release_inc;

   // Saturating counter increments
   assign hold_inc    = (hold_ff == 16'hFFFF) ? hold_ff : hold_ff + 16'd1;
   assign release_inc = (release_ff == 8'hFF) ? release_ff : release_ff + 8'd1;

   // Next state and event for the current sample
   always_comb begin
      phase_in   = phase_ff;
      hold_in    = hold_ff;
      release_in = release_ff;
      long_in    = long_ff;
      event_res  = kslp_pkg::EV_NONE;
      case (phase_ff)
         PH_IDLE: begin
            if (key_pressed) begin
               phase_in   = PH_CONFIRM;
               hold_in    = 16'd0;
               release_in = 8'd0;
            end
         end
         PH_CONFIRM: begin
            if (key_pressed) begin
               hold_in = hold_inc;
               if (hold_inc > cfg.confirm_ticks) begin
                  long_in  = 1'b0;
                  hold_in  = 16'd0;
                  phase_in = PH_HELD;
               end
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_HELD: begin
            if (key_pressed) begin
               hold_in = hold_inc;
               if (hold_inc > cfg.long_ticks) begin
                  long_in  = 1'b1;
                  hold_in  = 16'd0;
                  phase_in = PH_REPORT;
               end
            end else begin
               // first release classifies short; count carries into wait
               release_in = release_inc;
               long_in    = 1'b0;
               phase_in   = PH_REPORT;
            end
         end
         PH_REPORT: begin
            event_res = long_ff ? kslp_pkg::EV_LONG : kslp_pkg::EV_SHORT;
            phase_in  = PH_WAIT;
         end
         PH_WAIT: begin
            // a pressed sample is ignored here
            if (!key_pressed) begin
               release_in = release_inc;
               if (release_inc > cfg.settle_ticks) begin
                  phase_in = PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Advance the machine on each accepted sample
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         hold_ff    <= 16'd0;
         release_ff <= 8'd0;
         long_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         hold_ff    <= hold_in;
         release_ff <= release_in;
         long_ff    <= long_in;
      end
   end

endmodule

// ----- hw/rtl/key_short_long_press_classifier.sv -----
// ---------------------------------------------------------------------------
// key_short_long_press_classifier
// Debounced single-key classifier reporting short and long presses.
// ---------------------------------------------------------------------------
//  Channel   Direction  Payload                    Beat rule
//  req_*     in         tdata[0] key_pressed       tvalid & tready
//  rsp_*     out        tdata[1:0] event_res       tvalid & tready
//  csr_*     in         index 0..2, 16-bit data    csr_we
//
//  Every sample beat yields one result beat the cycle after acceptance.
//  One sample per cycle is sustained; the state update is a single pass
//  of counter increment and compare in front of the result register.
//  req_tready drops only while a result is held by a stalled rsp side.
//  Synchronous reset restores the thresholds and returns the key to idle.
// ---------------------------------------------------------------------------
module key_short_long_press_classifier (
   input  logic        clock,
   input  logic        reset,
   // sample channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] key_pressed, [7:1] zero fill
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [1:0] event_res, [7:2] zero fill
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   kslp_pkg::cfg_type cfg_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        event_ff;
   logic [1:0]        event_step;
   logic              req_beat;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;

   // Threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.confirm_ticks <= kslp_pkg::CONFIRM_RESET;
         cfg_ff.long_ticks    <= kslp_pkg::LONG_RESET;
         cfg_ff.settle_ticks  <= kslp_pkg::SETTLE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            kslp_pkg::REG_CONFIRM: cfg_ff.confirm_ticks <= csr_wdata;
            kslp_pkg::REG_LONG:    cfg_ff.long_ticks    <= csr_wdata;
            kslp_pkg::REG_SETTLE:  cfg_ff.settle_ticks  <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   kslp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (req_beat),
      .key_pressed (req_tdata[0]),
      .cfg         (cfg_ff),
      .event_res   (event_step)
   );

   // Result register: load on a sample beat, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_beat) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         event_ff <= event_step;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, event_ff};

endmodule

// ----- hw/rtl/kslp_checker.sv -----
// ---------------------------------------------------------------------------
// kslp_checker
// Port-level checks on the key press classifier, bound to the top level.
// ---------------------------------------------------------------------------
`include "key_short_long_press_classifier_defines.svh"

module kslp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // Nothing left to deliver right after reset
   `KSLP_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

   // Every accepted sample shows a result on the next cycle
   `KSLP_ASSERT_NEXT(a_sample_result, clock, reset, req_tvalid && req_tready, rsp_tvalid)

   // An empty result register never blocks the sample side
   `KSLP_ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)

   // Results carry a legal event code and zero fill
   `KSLP_ASSERT_IMPLY(a_event_legal, clock, reset, rsp_tvalid,
      (rsp_tdata[7:2] == 6'd0) &&
      ((rsp_tdata[1:0] == kslp_pkg::EV_NONE) ||
       (rsp_tdata[1:0] == kslp_pkg::EV_SHORT) ||
       (rsp_tdata[1:0] == kslp_pkg::EV_LONG)))

   // A stalled result holds
   `KSLP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

endmodule

bind key_short_long_press_classifier kslp_checker u_kslp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/tb_key_short_long_press_classifier.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Key press classifier testbench
// Streams key samples into the classifier under random sender gaps and
// receiver stalls. Each result beat is checked against an in-bench model of
// the debounce/short/long machine. The run covers several timing settings,
// including both extremes of every threshold.
// ----------------------------------------------------------------------------
module tb_key_short_long_press_classifier;

   localparam int         CYCLE_LIMIT = 400000;
   localparam int         PRINT_LIMIT = 20;
   localparam logic [1:0] REG_UNUSED  = 2'd3;   // index past the register file

   typedef enum logic [2:0] {
      KEY_IDLE, KEY_CONFIRM, KEY_HELD, KEY_REPORT, KEY_WAIT
   } key_phase_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'd0;   // [0] key_pressed, [7:1] zero fill
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;            // [1:0] event_res, [7:2] zero fill
   logic        csr_we      = 1'b0;
   logic [1:0]  csr_index   = 2'd0;
   logic [15:0] csr_wdata   = 16'd0;

   // Pending samples and expected events
   logic       key_q[$];
   logic [1:0] event_q[$];

   // Model copy of the thresholds and the key state
   kslp_pkg::cfg_type key_cfg;
   key_phase_type     key_phase;
   logic [15:0]       hold_cnt;
   logic [7:0]        rel_cnt;
   logic              long_seen;

   // Thresholds as the stimulus knows them, to shape press lengths
   int unsigned stim_confirm = kslp_pkg::CONFIRM_RESET;
   int unsigned stim_long    = kslp_pkg::LONG_RESET;
   int unsigned stim_settle  = kslp_pkg::SETTLE_RESET;

   bit req_taken, rsp_taken;
   bit send_calm, recv_calm;
   int send_wait, recv_wait;
   int stall_request, stall_left;
   int cycle_count, errors, items_pushed, n_settings, n_short, n_long;

   key_short_long_press_classifier DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Advance the key machine by one sample and return the event it emits
   function automatic logic [1:0] classify_sample(input logic pressed);
      logic [1:0] ev;
      ev = kslp_pkg::EV_NONE;
      case (key_phase)
         KEY_IDLE: begin
            if (pressed) begin
               key_phase = KEY_CONFIRM;
               hold_cnt  = '0;
               rel_cnt   = '0;
            end
         end
         KEY_CONFIRM: begin
            if (pressed) begin
               if (hold_cnt != 16'hFFFF) hold_cnt = hold_cnt + 16'd1;
               if (hold_cnt > key_cfg.confirm_ticks) begin
                  long_seen = 1'b0;
                  hold_cnt  = '0;
                  key_phase = KEY_HELD;
               end
            end else begin
               key_phase = KEY_IDLE;
            end
         end
         KEY_HELD: begin
            if (pressed) begin
               if (hold_cnt != 16'hFFFF) hold_cnt = hold_cnt + 16'd1;
               if (hold_cnt > key_cfg.long_ticks) begin
                  long_seen = 1'b1;
                  hold_cnt  = '0;
                  key_phase = KEY_REPORT;
               end
            end else begin
               if (rel_cnt != 8'hFF) rel_cnt = rel_cnt + 8'd1;
               if (rel_cnt != 8'd0) begin
                  long_seen = 1'b0;
                  key_phase = KEY_REPORT;
               end
            end
         end
         KEY_REPORT: begin
            ev = long_seen ? kslp_pkg::EV_LONG : kslp_pkg::EV_SHORT;
            key_phase = KEY_WAIT;
         end
         KEY_WAIT: begin
            // a press here is ignored; releases count toward re-arming
            if (!pressed) begin
               if (rel_cnt != 8'hFF) rel_cnt = rel_cnt + 8'd1;
               if (rel_cnt > key_cfg.settle_ticks) key_phase = KEY_IDLE;
            end
         end
         default: key_phase = KEY_IDLE;
      endcase
      return ev;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      errors++;
      if (errors <= PRINT_LIMIT)
         $display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, want);
   endtask

   // Monitor: track config writes, predict on sample beats, check result beats
   always @(posedge clock) begin : monitor
      logic [7:0] want;
      req_taken = !reset && req_tvalid && req_tready;
      rsp_taken = !reset && rsp_tvalid && rsp_tready;
      if (reset) begin
         key_cfg.confirm_ticks = kslp_pkg::CONFIRM_RESET;
         key_cfg.long_ticks    = kslp_pkg::LONG_RESET;
         key_cfg.settle_ticks  = kslp_pkg::SETTLE_RESET;
         key_phase = KEY_IDLE;
         hold_cnt  = '0;
         rel_cnt   = '0;
         long_seen = 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               kslp_pkg::REG_CONFIRM: key_cfg.confirm_ticks = csr_wdata;
               kslp_pkg::REG_LONG:    key_cfg.long_ticks    = csr_wdata;
               kslp_pkg::REG_SETTLE:  key_cfg.settle_ticks  = csr_wdata[7:0];
               default:     ;   // unknown index writes nothing
            endcase
         end
         if (req_taken) event_q.push_back(classify_sample(req_tdata[0]));
         if (rsp_taken) begin
            if (event_q.size() == 0) begin
               report_mismatch("result beat with no sample pending", rsp_tdata, 8'hxx);
            end else begin
               want = {6'd0, event_q.pop_front()};
               if (rsp_tdata !== want) report_mismatch("event_res", rsp_tdata, want);
               if (want[1:0] == kslp_pkg::EV_SHORT) n_short++;
               if (want[1:0] == kslp_pkg::EV_LONG)  n_long++;
            end
         end
      end
   end

   // Sender: offer queued samples, idle for a random gap after each beat
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait = 0;
      end else if (!req_tvalid || req_taken) begin
         if (req_taken) send_wait = send_calm ? 0 : $urandom_range(0, 4);
         if (send_wait == 0 && key_q.size() != 0) begin
            req_tdata  <= {7'd0, key_q.pop_front()};
            req_tvalid <= 1'b1;
         end else begin
            if (send_wait != 0) send_wait--;
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: stall for a random gap after each result, or a long stretch on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
         end
         if (rsp_taken) recv_wait = recv_calm ? 0 : $urandom_range(0, 4);
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (recv_wait != 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   task automatic push_run(input logic key, input int n);
      repeat (n) key_q.push_back(key);
      items_pushed += n;
   endtask

   // Push the low n bits, oldest sample in the highest bit
   task automatic push_bits(input logic [31:0] bits, input int n);
      for (int i = n - 1; i >= 0; i--) push_run(bits[i], 1);
   endtask

   // Cap a run length so huge thresholds do not blow up the run
   function automatic int reach(input int want);
      return (want > 240) ? int'($urandom_range(1, 240)) : want;
   endfunction

   // Hold until every sample is accepted and every result has come back
   task automatic wait_drained();
      do @(posedge clock);
      while (key_q.size() != 0 || req_tvalid || event_q.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_timing(input int unsigned c, input int unsigned l,
                             input int unsigned s);
      logic [31:0] junk;
      junk = $urandom;
      wait_drained();
      write_reg(kslp_pkg::REG_CONFIRM, c[15:0]);
      write_reg(kslp_pkg::REG_LONG, l[15:0]);
      // upper data bits are outside the 8-bit register and must be dropped
      write_reg(kslp_pkg::REG_SETTLE, {junk[7:0], s[7:0]});
      stim_confirm = c;
      stim_long    = l;
      stim_settle  = s;
      n_settings++;
   endtask

   // One random key gesture: noise, a bounce, or a full short/long press
   task automatic one_press();
      int kind, run, lead;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         repeat ($urandom_range(1, 8)) push_run(1'($urandom_range(0, 1)), 1);
      end else if (kind < 4) begin
         // release somewhere around the confirm point
         push_run(1'b1, $urandom_range(1, reach(stim_confirm + 2)));
         push_run(1'b0, $urandom_range(1, 3));
      end else begin
         push_run(1'b1, reach(stim_confirm + 2));
         if ($urandom_range(0, 1))
            push_run(1'b1, reach(stim_long + 1) + $urandom_range(0, 3));
         else
            push_run(1'b1, $urandom_range(0, reach(stim_long)));
         // release, now and then touching the key again before re-arming
         run = reach(stim_settle + 3) + $urandom_range(0, 2);
         if ($urandom_range(0, 4) == 0) begin
            lead = $urandom_range(1, run);
            push_run(1'b0, lead);
            push_run(1'b1, $urandom_range(1, 4));
            push_run(1'b0, run - lead + 1);
         end else begin
            push_run(1'b0, run);
         end
      end
   endtask

   task automatic run_presses(input int quota);
      int start;
      start = items_pushed;
      while (items_pushed - start < quota) one_press();
   endtask

   // Stimulus
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset thresholds: short presses and bounces only
      n_settings = 1;
      push_run(1'b1, 52);
      push_run(1'b0, 4);
      run_presses(60);

      // lowest thresholds, directed: idle, bounce, short, long with press in wait
      set_timing(0, 0, 0);
      send_calm = 1;
      recv_calm = 1;
      push_bits(32'b0_10_11000_1111110, 15);
      wait_drained();
      // out-of-range index must leave every threshold alone
      write_reg(REG_UNUSED, 16'hFFFF);
      push_bits(32'b11000, 5);
      run_presses(90);
      send_calm = 0;
      recv_calm = 0;

      // settle at max: release count saturates and the key never re-arms
      set_timing(0, 0, 255);
      push_bits(32'b110, 3);
      push_run(1'b0, 270);
      push_bits(32'b11, 2);
      wait_drained();
      write_reg(kslp_pkg::REG_SETTLE, 16'd0);
      stim_settle = 0;
      push_bits(32'b0110, 4);

      // confirm threshold out of reach: never confirmed
      set_timing(65535, 0, 0);
      push_run(1'b1, 220);
      push_run(1'b0, 2);

      // long threshold out of reach: never classified long
      set_timing(0, 65535, 3);
      push_run(1'b1, 220);
      push_run(1'b0, 6);

      // small thresholds with a long receiver stall against a busy sender
      set_timing(1, 2, 1);
      send_calm = 1;
      stall_request = 60;
      run_presses(60);
      wait_drained();
      send_calm = 0;
      run_presses(70);

      set_timing(3, 12, 4);
      run_presses(100);

      // random small thresholds, no idling on one side then the other
      set_timing($urandom_range(0, 8), $urandom_range(0, 30), $urandom_range(0, 10));
      recv_calm = 1;
      run_presses(80);
      recv_calm = 0;
      set_timing($urandom_range(0, 8), $urandom_range(0, 30), $urandom_range(0, 10));
      send_calm = 1;
      run_presses(80);
      send_calm = 0;

      // top of the allowed ranges
      set_timing(65534, 65534, 254);
      run_presses(1);
      set_timing(2, 65534, 0);
      run_presses(1);

      wait_drained();
      repeat (4) @(posedge clock);
      while (event_q.size() != 0)
         report_mismatch("result never delivered", 8'hxx, {6'd0, event_q.pop_front()});

      $display("covered %0d key samples over %0d timing settings", items_pushed, n_settings);
      $display("checked %0d short and %0d long press events, %0d mismatches",
               n_short, n_long, errors);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
